FILE: rtl/ihex_pkg.sv
// ----------------------------------------------------------------------------
// Intel HEX record parser package
// Word types, result kinds and error codes shared by the parser modules.
// ----------------------------------------------------------------------------
package ihex_pkg;

    localparam int ADDR_WIDTH = 16;
    localparam int SPAN_WIDTH = ADDR_WIDTH + 1;

    localparam logic [SPAN_WIDTH-1:0] ADDR_NONE = SPAN_WIDTH'(1) << ADDR_WIDTH;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    typedef enum logic [1:0] {
        KIND_DATA    = 2'd0,
        KIND_ERROR   = 2'd1,
        KIND_SUMMARY = 2'd2
    } result_kind_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_NO_COLON  = 3'd1,
        ERR_BAD_DIGIT = 3'd2,
        ERR_BAD_TYPE  = 3'd3,
        ERR_CHECKSUM  = 3'd4,
        ERR_TRUNCATED = 3'd5
    } error_code_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_input;
    } ihex_in_t;

    typedef struct packed {
        logic [1:0]            result_kind;
        logic [SPAN_WIDTH-1:0] address;
        logic [7:0]            data_byte;
        logic [SPAN_WIDTH-1:0] span_size;
        logic [2:0]            error_code;
    } ihex_out_t;

endpackage

FILE: rtl/intel_hex_record_parser.sv
// ----------------------------------------------------------------------------
// Intel HEX record parser
// Parses Intel HEX text one character per word and emits data bytes with
// their addresses, error reports and an end-of-input summary.
// ----------------------------------------------------------------------------
// Each character word is captured in an input register and parsed, and its
// result, if any, is loaded into an output register when the parse step
// advances. With the receiver ready the block takes one word per clock cycle.
// While a result waits in the output register the parse step holds, the
// input register takes at most one more word, and the input then stalls
// until the result is taken.
module intel_hex_record_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  ihex_pkg::ihex_in_t  item,
    output logic                result_valid,
    input  logic                result_ready,
    output ihex_pkg::ihex_out_t result
);
    import ihex_pkg::*;

    ihex_in_t  item_reg;
    logic      item_valid_reg;
    ihex_out_t result_reg;
    logic      result_valid_reg;

    logic      advance;
    logic      step_has_result;
    ihex_out_t step_result;

    assign advance    = item_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !item_valid_reg || advance;

    ihex_step u_step (
        .clk        (clk),
        .rst_n      (rst_n),
        .enable     (advance),
        .word       (item_reg),
        .has_result (step_has_result),
        .result     (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_ready)
            begin
                item_valid_reg <= item_valid;
            end
            if (advance)
            begin
                result_valid_reg <= step_has_result;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            item_reg <= item;
        end
        if (advance && step_has_result)
        begin
            result_reg <= step_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

FILE: rtl/ihex_step.sv
// ----------------------------------------------------------------------------
// Intel HEX record parser step
// Holds the record parse state and the address range, and works out the
// update and the optional result for one character word.
// ----------------------------------------------------------------------------
module ihex_step (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              enable,
    input  ihex_pkg::ihex_in_t  word,
    output logic              has_result,
    output ihex_pkg::ihex_out_t result
);
    import ihex_pkg::*;

    typedef enum logic [6:0] {
        PH_START   = 7'b0000001,
        PH_COUNT   = 7'b0000010,
        PH_ADDR    = 7'b0000100,
        PH_TYPE    = 7'b0001000,
        PH_DATA    = 7'b0010000,
        PH_CSUM    = 7'b0100000,
        PH_BETWEEN = 7'b1000000
    } phase_t;

    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'h10;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = {1'b0, 4'(c - 8'h30)};
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            v = {1'b0, 4'(c - 8'h37)};
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            v = {1'b0, 4'(c - 8'h57)};
        end
        return v;
    endfunction

    phase_t                phase_reg, phase_next;
    logic [1:0]            digit_reg, digit_next;
    logic [3:0]            nibble_reg, nibble_next;
    logic [7:0]            left_reg, left_next;
    logic [ADDR_WIDTH-1:0] rec_addr_reg, rec_addr_next;
    logic [7:0]            sum_reg, sum_next;
    logic [SPAN_WIDTH-1:0] lowest_reg, lowest_next;
    logic [ADDR_WIDTH-1:0] highest_reg, highest_next;
    logic                  seen_reg, seen_next;
    error_code_t           sticky_reg, sticky_next;

    logic [4:0]  hex;
    logic [7:0]  byte_val;
    logic [7:0]  sum_add;
    error_code_t summary_code;
    logic        in_record;

    assign hex      = hex_value(word.ch);
    assign byte_val = {nibble_reg, hex[3:0]};
    assign sum_add  = sum_reg + byte_val;
    assign in_record = (phase_reg == PH_COUNT) || (phase_reg == PH_ADDR) ||
                       (phase_reg == PH_TYPE) || (phase_reg == PH_DATA) ||
                       (phase_reg == PH_CSUM);

    always_comb
    begin
        phase_next    = phase_reg;
        digit_next    = digit_reg;
        nibble_next   = nibble_reg;
        left_next     = left_reg;
        rec_addr_next = rec_addr_reg;
        sum_next      = sum_reg;
        lowest_next   = lowest_reg;
        highest_next  = highest_reg;
        seen_next     = seen_reg;
        sticky_next   = sticky_reg;
        has_result    = 1'b0;
        result        = '0;
        summary_code  = sticky_reg;

        if (word.end_of_input)
        begin
            if (sticky_reg == ERR_NONE && in_record)
            begin
                summary_code = ERR_TRUNCATED;
            end
            has_result         = 1'b1;
            result.result_kind = KIND_SUMMARY;
            result.address     = lowest_reg;
            result.error_code  = summary_code;
            if (seen_reg)
            begin
                result.span_size = {1'b0, highest_reg} - lowest_reg + SPAN_WIDTH'(1);
            end
            phase_next    = PH_START;
            digit_next    = '0;
            nibble_next   = '0;
            left_next     = '0;
            rec_addr_next = '0;
            sum_next      = '0;
            lowest_next   = ADDR_NONE;
            highest_next  = '0;
            seen_next     = 1'b0;
            sticky_next   = ERR_NONE;
        end
        else if (sticky_reg != ERR_NONE)
        begin
            has_result = 1'b0;
        end
        else if (phase_reg == PH_START || phase_reg == PH_BETWEEN)
        begin
            if (phase_reg == PH_BETWEEN && (word.ch == CHAR_CR || word.ch == CHAR_LF))
            begin
                has_result = 1'b0;
            end
            else if (word.ch == CHAR_COLON)
            begin
                phase_next    = PH_COUNT;
                digit_next    = '0;
                nibble_next   = '0;
                sum_next      = '0;
                rec_addr_next = '0;
                left_next     = '0;
            end
            else
            begin
                sticky_next = ERR_NO_COLON;
            end
        end
        else if (hex[4])
        begin
            sticky_next = ERR_BAD_DIGIT;
        end
        else if (!digit_reg[0])
        begin
            nibble_next = hex[3:0];
            digit_next  = digit_reg + 2'd1;
        end
        else
        begin
            sum_next   = sum_add;
            digit_next = '0;
            unique case (phase_reg)
                PH_COUNT:
                begin
                    left_next  = byte_val;
                    phase_next = PH_ADDR;
                end
                PH_ADDR:
                begin
                    rec_addr_next = {rec_addr_reg[ADDR_WIDTH-9:0], byte_val};
                    if (digit_reg == 2'd3)
                    begin
                        phase_next = PH_TYPE;
                    end
                    else
                    begin
                        digit_next = 2'd2;
                    end
                end
                PH_TYPE:
                begin
                    if (byte_val > 8'd1)
                    begin
                        sticky_next = ERR_BAD_TYPE;
                    end
                    else
                    begin
                        phase_next = (left_reg != '0) ? PH_DATA : PH_CSUM;
                    end
                end
                PH_DATA:
                begin
                    has_result         = 1'b1;
                    result.result_kind = KIND_DATA;
                    result.address     = {1'b0, rec_addr_reg};
                    result.data_byte   = byte_val;
                    if ({1'b0, rec_addr_reg} < lowest_reg)
                    begin
                        lowest_next = {1'b0, rec_addr_reg};
                    end
                    if (rec_addr_reg > highest_reg)
                    begin
                        highest_next = rec_addr_reg;
                    end
                    seen_next     = 1'b1;
                    rec_addr_next = rec_addr_reg + ADDR_WIDTH'(1);
                    left_next     = left_reg - 8'd1;
                    if (left_reg == 8'd1)
                    begin
                        phase_next = PH_CSUM;
                    end
                end
                PH_CSUM:
                begin
                    if (sum_add != '0)
                    begin
                        sticky_next = ERR_CHECKSUM;
                    end
                    else
                    begin
                        phase_next = PH_BETWEEN;
                    end
                end
                default:
                begin
                    sticky_next = ERR_NO_COLON;
                end
            endcase
        end

        if (!word.end_of_input && sticky_reg == ERR_NONE && sticky_next != ERR_NONE)
        begin
            has_result         = 1'b1;
            result.result_kind = KIND_ERROR;
            result.error_code  = sticky_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_START;
            digit_reg    <= '0;
            nibble_reg   <= '0;
            left_reg     <= '0;
            rec_addr_reg <= '0;
            sum_reg      <= '0;
            lowest_reg   <= ADDR_NONE;
            highest_reg  <= '0;
            seen_reg     <= 1'b0;
            sticky_reg   <= ERR_NONE;
        end
        else if (enable)
        begin
            phase_reg    <= phase_next;
            digit_reg    <= digit_next;
            nibble_reg   <= nibble_next;
            left_reg     <= left_next;
            rec_addr_reg <= rec_addr_next;
            sum_reg      <= sum_next;
            lowest_reg   <= lowest_next;
            highest_reg  <= highest_next;
            seen_reg     <= seen_next;
            sticky_reg   <= sticky_next;
        end
    end

endmodule

FILE: dv/intel_hex_record_parser_tb.sv
// ----------------------------------------------------------------------------
// Intel HEX record parser testbench
// Sends hex text one character word at a time and predicts every data byte,
// error report and end summary. Each result is compared in order with the
// prediction, under random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module intel_hex_record_parser_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ihex_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;

    typedef enum logic [2:0] {
        WAIT_COLON,
        IN_COUNT,
        IN_ADDR,
        IN_TYPE,
        IN_DATA,
        IN_CHECKSUM,
        BETWEEN_RECORDS
    } parse_phase_t;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      item_valid;
    logic      item_ready;
    ihex_in_t  item;
    logic      result_valid;
    logic      result_ready;
    ihex_out_t result;

    parse_phase_t phase;
    logic [1:0]   digit_pos;
    logic [3:0]   upper_nibble;
    logic [7:0]   bytes_left;
    logic [15:0]  rec_addr;
    logic [7:0]   byte_sum;
    logic [16:0]  low_addr;
    logic [15:0]  high_addr;
    logic         data_seen;
    error_code_t  held_error;

    ihex_out_t   expected_results[$];
    logic [7:0]  hex_text[$];

    int  words_sent = 0;
    int  mismatch_count = 0;
    int  idle_cycles = 0;
    int  data_checked = 0;
    int  errors_checked = 0;
    int  summaries_checked = 0;
    bit  codes_seen[8];
    bit  sender_no_gaps = 1'b0;
    int  send_calm = 0;
    int  recv_calm = 0;
    int  hold_off_cycles = 0;

    intel_hex_record_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #1 clk = ~clk;

    function automatic int pick_wait(inout int calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0)
            calm_left = $urandom_range(20, 60);
        return $urandom_range(0, 11);
    endfunction

    function automatic logic [4:0] nibble_of(logic [7:0] c);
        if (c >= "0" && c <= "9")
            return 5'(c - 8'h30);
        if (c >= "A" && c <= "F")
            return 5'(c - 8'h41 + 8'd10);
        if (c >= "a" && c <= "f")
            return 5'(c - 8'h61 + 8'd10);
        return 5'd16;
    endfunction

    function automatic ihex_out_t make_result(result_kind_t kind, logic [16:0] addr,
                                              logic [7:0] data, logic [16:0] size,
                                              error_code_t code);
        ihex_out_t r;
        r.result_kind = kind;
        r.address     = addr;
        r.data_byte   = data;
        r.span_size   = size;
        r.error_code  = code;
        return r;
    endfunction

    task automatic clear_parser_state();
        phase        = WAIT_COLON;
        digit_pos    = '0;
        upper_nibble = '0;
        bytes_left   = '0;
        rec_addr     = '0;
        byte_sum     = '0;
        low_addr     = ADDR_NONE;
        high_addr    = '0;
        data_seen    = 1'b0;
        held_error   = ERR_NONE;
    endtask

    task automatic push_error(error_code_t code);
        held_error = code;
        expected_results.push_back(make_result(KIND_ERROR, '0, '0, '0, code));
    endtask

    task automatic predict_word(ihex_in_t w);
        logic [4:0]  n;
        logic [7:0]  b;
        logic [16:0] size;
        error_code_t code;
        if (w.end_of_input)
        begin
            code = held_error;
            if (code == ERR_NONE && phase >= IN_COUNT && phase <= IN_CHECKSUM)
                code = ERR_TRUNCATED;
            size = data_seen ? 17'(high_addr) - low_addr + 17'd1 : 17'd0;
            expected_results.push_back(make_result(KIND_SUMMARY, low_addr, '0, size, code));
            clear_parser_state();
            return;
        end
        if (held_error != ERR_NONE)
            return;
        if (phase == WAIT_COLON || phase == BETWEEN_RECORDS)
        begin
            if (phase == BETWEEN_RECORDS && (w.ch == CHAR_CR || w.ch == CHAR_LF))
                return;
            if (w.ch == CHAR_COLON)
            begin
                phase        = IN_COUNT;
                digit_pos    = '0;
                upper_nibble = '0;
                byte_sum     = '0;
                rec_addr     = '0;
                bytes_left   = '0;
                return;
            end
            push_error(ERR_NO_COLON);
            return;
        end
        n = nibble_of(w.ch);
        if (n[4])
        begin
            push_error(ERR_BAD_DIGIT);
            return;
        end
        if (!digit_pos[0])
        begin
            upper_nibble = n[3:0];
            digit_pos++;
            return;
        end
        b = {upper_nibble, n[3:0]};
        byte_sum = byte_sum + b;
        case (phase)
            IN_COUNT:
            begin
                bytes_left = b;
                phase = IN_ADDR;
                digit_pos = '0;
            end
            IN_ADDR:
            begin
                rec_addr = {rec_addr[7:0], b};
                if (digit_pos == 2'd3)
                begin
                    phase = IN_TYPE;
                    digit_pos = '0;
                end
                else
                    digit_pos = 2'd2;
            end
            IN_TYPE:
            begin
                if (b > 8'd1)
                    push_error(ERR_BAD_TYPE);
                else
                begin
                    phase = (bytes_left != 0) ? IN_DATA : IN_CHECKSUM;
                    digit_pos = '0;
                end
            end
            IN_DATA:
            begin
                expected_results.push_back(make_result(KIND_DATA, {1'b0, rec_addr}, b,
                                                       '0, ERR_NONE));
                if ({1'b0, rec_addr} < low_addr)
                    low_addr = {1'b0, rec_addr};
                if (rec_addr > high_addr)
                    high_addr = rec_addr;
                data_seen = 1'b1;
                rec_addr++;
                bytes_left--;
                if (bytes_left == 0)
                    phase = IN_CHECKSUM;
                digit_pos = '0;
            end
            default:
            begin
                if (byte_sum != 0)
                    push_error(ERR_CHECKSUM);
                else
                begin
                    phase = BETWEEN_RECORDS;
                    digit_pos = '0;
                end
            end
        endcase
    endtask

    task automatic send_word(logic [7:0] ch, logic eoi);
        ihex_in_t w;
        int       gap;
        w.ch = ch;
        w.end_of_input = eoi;
        gap = sender_no_gaps ? 0 : pick_wait(send_calm);
        repeat (gap)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
        end
        @(negedge clk);
        item_valid <= 1'b1;
        item <= w;
        do
            @(posedge clk);
        while (!item_ready);
        predict_word(w);
        words_sent++;
    endtask

    function automatic logic [7:0] hex_digit(logic [3:0] v);
        if (v < 4'd10)
            return 8'h30 + 8'(v);
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
    endfunction

    task automatic push_text(string s);
        for (int i = 0; i < s.len(); i++)
            hex_text.push_back(s[i]);
    endtask

    task automatic push_hex_byte(logic [7:0] b);
        hex_text.push_back(hex_digit(b[7:4]));
        hex_text.push_back(hex_digit(b[3:0]));
    endtask

    task automatic push_record(int count, logic [15:0] addr, logic [7:0] rtype, bit bad_sum);
        logic [7:0] sum;
        logic [7:0] d;
        hex_text.push_back(CHAR_COLON);
        sum = 8'(count) + addr[15:8] + addr[7:0] + rtype;
        push_hex_byte(8'(count));
        push_hex_byte(addr[15:8]);
        push_hex_byte(addr[7:0]);
        push_hex_byte(rtype);
        for (int i = 0; i < count; i++)
        begin
            d = 8'($urandom_range(0, 255));
            sum = sum + d;
            push_hex_byte(d);
        end
        sum = -sum;
        if (bad_sum)
            sum = sum ^ 8'($urandom_range(1, 255));
        push_hex_byte(sum);
        repeat ($urandom_range(0, 3))
            hex_text.push_back($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
    endtask

    task automatic send_text_and_end();
        while (hex_text.size() > 0)
            send_word(hex_text.pop_front(), 1'b0);
        send_word(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic test_special_cases();
        send_word(8'($urandom_range(0, 255)), 1'b1);
        send_word(CHAR_CR, 1'b0);
        send_word(8'($urandom_range(0, 255)), 1'b1);
        hex_text.push_back(CHAR_COLON);
        hex_text.push_back(8'h00);
        send_text_and_end();
        push_text(":00000002");
        send_text_and_end();
        push_text(":02FFFF00aBcD88");
        hex_text.push_back(CHAR_CR);
        hex_text.push_back(CHAR_LF);
        push_text(":00000001FF");
        send_text_and_end();
    endtask

    task automatic test_stalled_receiver();
        sender_no_gaps = 1'b1;
        hold_off_cycles = 300;
        push_record(32, 16'($urandom_range(0, 65535)), 8'h00, 1'b0);
        send_text_and_end();
        sender_no_gaps = 1'b0;
    endtask

    task automatic test_random_files(int word_count);
        int         stop_at;
        int         pos;
        logic [7:0] rtype;
        logic [15:0] addr;
        int         count;
        stop_at = words_sent + word_count;
        while (words_sent < stop_at)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 4))
                    hex_text.push_back(8'($urandom_range(0, 255)));
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                begin
                    if ($urandom_range(0, 59) == 0)
                        count = 255;
                    else if ($urandom_range(0, 7) == 0)
                        count = 0;
                    else
                        count = $urandom_range(1, 8);
                    if ($urandom_range(0, 3) == 0)
                        addr = 16'($urandom_range(16'hFFF8, 16'hFFFF));
                    else
                        addr = 16'($urandom_range(0, 65535));
                    case ($urandom_range(0, 19))
                        0:       rtype = 8'($urandom_range(2, 255));
                        1, 2, 3: rtype = 8'h01;
                        default: rtype = 8'h00;
                    endcase
                    push_record(count, addr, rtype, $urandom_range(0, 14) == 0);
                end
            end
            if ($urandom_range(0, 5) == 0 && hex_text.size() > 0)
            begin
                pos = $urandom_range(0, hex_text.size() - 1);
                case ($urandom_range(0, 2))
                    0: hex_text[pos] = 8'($urandom_range(0, 255));
                    1: while (hex_text.size() > pos)
                           void'(hex_text.pop_back());
                    default: hex_text.insert(pos, 8'($urandom_range(0, 255)));
                endcase
            end
            send_text_and_end();
        end
    endtask

    task automatic check_result(ihex_out_t got);
        ihex_out_t want;
        case (got.result_kind)
            KIND_DATA:    data_checked++;
            KIND_ERROR:   errors_checked++;
            KIND_SUMMARY: summaries_checked++;
            default:      ;
        endcase
        codes_seen[got.error_code] = 1'b1;
        if (expected_results.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("Unexpected result: kind %0d addr %h byte %h size %h code %0d",
                         got.result_kind, got.address, got.data_byte, got.span_size,
                         got.error_code);
            return;
        end
        want = expected_results.pop_front();
        if (got.result_kind !== want.result_kind || got.address !== want.address ||
            got.data_byte !== want.data_byte || got.span_size !== want.span_size ||
            got.error_code !== want.error_code)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
            begin
                $display("Mismatch: expected kind %0d addr %h byte %h size %h code %0d",
                         want.result_kind, want.address, want.data_byte, want.span_size,
                         want.error_code);
                $display("          actual   kind %0d addr %h byte %h size %h code %0d",
                         got.result_kind, got.address, got.data_byte, got.span_size,
                         got.error_code);
            end
        end
    endtask

    initial
    begin
        int stall;
        result_ready = 1'b0;
        forever
        begin
            if (hold_off_cycles > 0)
            begin
                stall = hold_off_cycles;
                hold_off_cycles = 0;
            end
            else
                stall = pick_wait(recv_calm);
            repeat (stall)
            begin
                @(negedge clk);
                result_ready <= 1'b0;
            end
            @(negedge clk);
            result_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(result_valid && result_ready));
            check_result(result);
        end
    end

    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: no word moved for %0d cycles", IDLE_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        int kinds;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        clear_parser_state();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_special_cases();
        test_stalled_receiver();
        test_random_files(1750 - words_sent);

        @(negedge clk);
        item_valid <= 1'b0;
        wait (expected_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        kinds = 0;
        for (int i = 1; i <= 5; i++)
            kinds += codes_seen[i];
        $display("Sent %0d character words; checked %0d data bytes,",
                 words_sent, data_checked);
        $display("%0d error reports and %0d summaries; distinct error codes %0d of 5.",
                 errors_checked, summaries_checked, kinds);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
